// ===== hdl/kpsc_pkg.sv =====
package kpsc_pkg;

   localparam int COL_W = 4;
   localparam int ROW_W = 4;
   localparam int CHAR_W = 7;
   localparam int VAL_W = 16;
   localparam int KEY_W = 5;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 16;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] REG_DEBOUNCE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_LIMIT = 2'd1;

   localparam logic [VAL_W-1:0] DEBOUNCE_RESET = 16'd5;
   localparam logic [VAL_W-1:0] LIMIT_RESET = 16'd600;

   // Scan phase codes.
   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_WAIT = 3'd1;
   localparam logic [2:0] PH_ROW0 = 3'd2;
   localparam logic [2:0] PH_ROW1 = 3'd3;
   localparam logic [2:0] PH_ROW2 = 3'd4;
   localparam logic [2:0] PH_ROW3 = 3'd5;

   localparam logic [KEY_W-1:0] KEY_NONE = 5'd0;

   localparam logic [CHAR_W-1:0] KC_ZERO = 7'h30;
   localparam logic [CHAR_W-1:0] KC_NINE = 7'h39;
   localparam logic [CHAR_W-1:0] KC_A = 7'h41;
   localparam logic [ROW_W-1:0] DRIVE_ALL = 4'hF;

   typedef struct packed {
      logic [2:0]       phase;
      logic [VAL_W-1:0] wait_count;
      logic [KEY_W-1:0] found_key;
      logic [VAL_W-1:0] entry;
      logic [VAL_W-1:0] setpoint;
   } state_type;

   typedef struct packed {
      logic [VAL_W-1:0] debounce_ticks;
      logic [VAL_W-1:0] entry_limit;
   } cfg_type;

   typedef struct packed {
      logic [ROW_W-1:0]  row_drive;
      logic              key_valid;
      logic [CHAR_W-1:0] key_char;
      logic [VAL_W-1:0]  entry_value;
      logic [VAL_W-1:0]  setpoint;
      logic              setpoint_update;
   } result_type;

   // ASCII of the key at row * 4 + column.
   function automatic logic [CHAR_W-1:0] key_ascii(input logic [3:0] code);
      logic [CHAR_W-1:0] c;
      begin
         case (code)
            4'd0: c = 7'h44;  // D
            4'd1: c = 7'h43;  // C
            4'd2: c = 7'h42;  // B
            4'd3: c = 7'h41;  // A
            4'd4: c = 7'h23;  // #
            4'd5: c = 7'h39;  // 9
            4'd6: c = 7'h36;  // 6
            4'd7: c = 7'h33;  // 3
            4'd8: c = 7'h30;  // 0
            4'd9: c = 7'h38;  // 8
            4'd10: c = 7'h35; // 5
            4'd11: c = 7'h32; // 2
            4'd12: c = 7'h2A; // *
            4'd13: c = 7'h37; // 7
            4'd14: c = 7'h34; // 4
            4'd15: c = 7'h31; // 1
            default: c = 7'h00;
         endcase
         return c;
      end
   endfunction

endpackage

// ===== hdl/kpsc_step.sv =====
module kpsc_step (
   input  kpsc_pkg::state_type                 cur,
   input  kpsc_pkg::cfg_type                   cfg,
   input  logic [kpsc_pkg::COL_W-1:0]          cols,
   output kpsc_pkg::state_type                 nxt,
   output kpsc_pkg::result_type                res
);

   logic [1:0]                     row;
   logic [1:0]                     col;
   logic                           hit;
   logic [kpsc_pkg::KEY_W-1:0]     final_key;
   logic [kpsc_pkg::CHAR_W-1:0]    ch;
   logic [3:0]                     digit;
   logic [kpsc_pkg::VAL_W+3:0]     grown;
   logic [2:0]                     row_off;

   always_comb begin
      row = 2'(cur.phase - kpsc_pkg::PH_ROW0);
      hit = 1'b1;
      col = 2'd0;
      case (cols)
         4'h1: col = 2'd0;
         4'h2: col = 2'd1;
         4'h4: col = 2'd2;
         4'h8: col = 2'd3;
         default: hit = 1'b0;
      endcase
      final_key = hit ? {1'b1, row, col} : cur.found_key;
      ch = kpsc_pkg::key_ascii(final_key[3:0]);
      digit = 4'(ch - kpsc_pkg::KC_ZERO);
      // Times ten as two shifted copies.
      grown = {3'b000, cur.entry, 1'b0} + {1'b0, cur.entry, 3'b000} + 20'(digit);
   end

   always_comb begin
      nxt = cur;
      res = '0;
      case (cur.phase)
         kpsc_pkg::PH_WAIT: begin
            if (cur.wait_count < cfg.debounce_ticks) begin
               nxt.wait_count = cur.wait_count + 16'd1;
            end else if (cols == '0) begin
               nxt.phase = kpsc_pkg::PH_IDLE;
            end else begin
               nxt.found_key = kpsc_pkg::KEY_NONE;
               nxt.phase = kpsc_pkg::PH_ROW0;
            end
         end
         kpsc_pkg::PH_ROW0, kpsc_pkg::PH_ROW1, kpsc_pkg::PH_ROW2: begin
            nxt.found_key = final_key;
            nxt.phase = cur.phase + 3'd1;
         end
         kpsc_pkg::PH_ROW3: begin
            // The scan is over: report the last row that decoded.
            if (final_key[kpsc_pkg::KEY_W-1]) begin
               res.key_valid = 1'b1;
               res.key_char = ch;
               if (ch inside {[kpsc_pkg::KC_ZERO:kpsc_pkg::KC_NINE]}) begin
                  if (grown >= {4'b0000, cfg.entry_limit}) begin
                     nxt.entry = cfg.entry_limit;
                  end else begin
                     nxt.entry = grown[kpsc_pkg::VAL_W-1:0];
                  end
               end else if (ch == kpsc_pkg::KC_A) begin
                  nxt.setpoint = cur.entry;
                  nxt.entry = '0;
                  res.setpoint_update = 1'b1;
               end
            end
            nxt.found_key = kpsc_pkg::KEY_NONE;
            nxt.phase = kpsc_pkg::PH_IDLE;
         end
         default: begin
            nxt.phase = kpsc_pkg::PH_IDLE;
            if (cols != '0) begin
               nxt.wait_count = '0;
               nxt.phase = kpsc_pkg::PH_WAIT;
            end
         end
      endcase

      row_off = nxt.phase - kpsc_pkg::PH_ROW0;
      if (nxt.phase inside {[kpsc_pkg::PH_ROW0:kpsc_pkg::PH_ROW3]}) begin
         res.row_drive = 4'b0001 << row_off[1:0];
      end else begin
         res.row_drive = kpsc_pkg::DRIVE_ALL;
      end
      res.entry_value = nxt.entry;
      res.setpoint = nxt.setpoint;
   end

endmodule

// ===== hdl/keypad_scanner_numeric_entry.sv =====
// 4x4 matrix keypad scanner with decimal entry. Each transfer on the req
// channel is one tick of column samples; each produces exactly one rsp
// transfer with the row drive to apply next, any key found by a completed
// scan, and the entry and setpoint values. One tick is taken every clock
// cycle unless the rsp channel back-pressures; a tick's result goes from the input
// register through the scan step into the result register. Registers are
// written through the csr channel, which is always ready: index 0 is the
// debounce time in ticks, index 1 the entry ceiling; other indexes are
// ignored. Write them only while no ticks are in flight.
module keypad_scanner_numeric_entry (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [kpsc_pkg::COL_W-1:0]          req_column_sense,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [kpsc_pkg::ROW_W-1:0]          rsp_row_drive,
   output logic                                rsp_key_valid,
   output logic [kpsc_pkg::CHAR_W-1:0]         rsp_key_char,
   output logic [kpsc_pkg::VAL_W-1:0]          rsp_entry_value,
   output logic [kpsc_pkg::VAL_W-1:0]          rsp_setpoint,
   output logic                                rsp_setpoint_update,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [kpsc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [kpsc_pkg::CSR_DATA_W-1:0]     csr_data
);

   logic                         in_valid_ff;
   logic [kpsc_pkg::COL_W-1:0]   in_cols_ff;
   logic                         rsp_valid_ff;
   kpsc_pkg::result_type         rsp_ff;
   kpsc_pkg::state_type          st_ff;
   kpsc_pkg::state_type          st_in;
   kpsc_pkg::result_type         res_in;
   kpsc_pkg::cfg_type            cfg_ff;
   logic                         advance;

   assign advance = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   kpsc_step u_step (
      .cur  (st_ff),
      .cfg  (cfg_ff),
      .cols (in_cols_ff),
      .nxt  (st_in),
      .res  (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         st_ff <= '{phase: kpsc_pkg::PH_IDLE, wait_count: '0,
                    found_key: kpsc_pkg::KEY_NONE, entry: '0, setpoint: '0};
         cfg_ff <= '{debounce_ticks: kpsc_pkg::DEBOUNCE_RESET,
                     entry_limit: kpsc_pkg::LIMIT_RESET};
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            st_ff <= st_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            case (csr_index)
               kpsc_pkg::REG_DEBOUNCE: cfg_ff.debounce_ticks <= csr_data;
               kpsc_pkg::REG_LIMIT: cfg_ff.entry_limit <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_cols_ff <= req_column_sense;
      end
      if (advance) begin
         rsp_ff <= res_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_row_drive = rsp_ff.row_drive;
   assign rsp_key_valid = rsp_ff.key_valid;
   assign rsp_key_char = rsp_ff.key_char;
   assign rsp_entry_value = rsp_ff.entry_value;
   assign rsp_setpoint = rsp_ff.setpoint;
   assign rsp_setpoint_update = rsp_ff.setpoint_update;

endmodule
